FILE: rtl/bts_pkg.sv
// Package with shared constants and types for the bitmask tiling search block.
`default_nettype none
package bts_pkg;
	localparam int NumCells = 64;
	localparam int NumPieces = 12;
	localparam int MaxPlacements = 8;
	localparam int BoardW = 64;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_SOLVE  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;
endpackage
`default_nettype wire

FILE: rtl/bitmask_tiling_backtrack_search.sv
// Top level of the bitmask tiling search: table storage, search sequencer and result output.
// Appends to the table are taken back to back; a clear of the count memory
// sweeps one row per cycle while the input is held off.
// A solve skips covered cells, rejects pieces, tries placements and backtracks; the latency
// is data dependent.
// Results then leave one per cycle as the output is taken.
// After reset a clearing pass zeroes the counts before input is taken.
`default_nettype none
module bitmask_tiling_backtrack_search import bts_pkg::*; #(
	parameter int NUM_CELLS = NumCells,
	parameter int NUM_PIECES = NumPieces,
	parameter int MAX_PLACEMENTS = MaxPlacements
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// tdata: opcode[1:0], cell_index[7:2], piece_index[11:8], board_mask[75:12], zero fill.
	input  wire logic [79:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// tdata: found[0], piece_valid[1], placed_piece[5:2], placed_mask[69:6], zero fill.
	output logic [71:0]      m_tdata,
	output logic             m_tlast
);
	localparam int CW = $clog2(NUM_CELLS);
	localparam int PW = (NUM_PIECES > 1) ? $clog2(NUM_PIECES) : 1;
	localparam int KW = (MAX_PLACEMENTS > 1) ? $clog2(MAX_PLACEMENTS) : 1;
	localparam int NW = $clog2(MAX_PLACEMENTS + 1);
	localparam int DW = $clog2(NUM_PIECES + 2);
	localparam int SD = NUM_PIECES + 1;

	typedef enum logic [8:0] {
		ST_INIT  = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_SKIP  = 9'b000000100,
		ST_CNT   = 9'b000001000,
		ST_FETCH = 9'b000010000,
		ST_TEST  = 9'b000100000,
		ST_POP   = 9'b001000000,
		ST_EMIT  = 9'b010000000,
		ST_CLR   = 9'b100000000
	} state_t;

	state_t state_q;
	logic [CW-1:0] clr_q;

	// Count memory: one row of NUM_PIECES counts per cell.
	logic [NUM_PIECES*NW-1:0] cnt_mem [NUM_CELLS];
	logic [NUM_PIECES*NW-1:0] cnt_rd_q;
	logic [63:0] tab_mem [NUM_CELLS*NUM_PIECES*MAX_PLACEMENTS];
	logic [63:0] tab_rd_q;

	logic [63:0] stk_mask [SD];
	logic [63:0] stk_cov [SD];
	logic [PW-1:0] stk_p [SD];
	logic [KW:0] stk_k [SD];
	logic [CW-1:0] stk_cell [SD];
	logic [NUM_PIECES-1:0] stk_used [SD];

	logic [CW:0] cell_q;
	logic [63:0] cov_q;
	logic [NUM_PIECES-1:0] used_q;
	logic [PW:0] p_q;
	logic [KW:0] k_q;
	logic [DW-1:0] depth_q;
	logic [DW-1:0] emit_q;
	logic [NW-1:0] cnt_cur;

	logic [1:0] op;
	logic [5:0] in_cell;
	logic [3:0] in_piece;
	logic [63:0] in_mask;
	logic s_fire, m_fire;
	logic out_v_q, out_found_q, out_pv_q, out_last_q;
	logic [3:0] out_piece_q;
	logic [63:0] out_mask_q;

	assign op = s_tdata[1:0];
	assign in_cell = s_tdata[7:2];
	assign in_piece = s_tdata[11:8];
	assign in_mask = s_tdata[75:12];
	assign s_tready = (state_q == ST_IDLE) && !out_v_q;
	assign s_fire = s_tvalid && s_tready;
	assign m_fire = m_tvalid && m_tready;
	assign m_tvalid = out_v_q;
	assign m_tlast = out_last_q;
	assign m_tdata = {2'b0, out_mask_q, out_piece_q, out_pv_q, out_found_q};

	logic app_ok;
	logic [NW-1:0] app_cnt;
	assign app_ok = (op == OP_APPEND) && ({26'b0, in_cell} < NUM_CELLS)
		&& ({28'b0, in_piece} < NUM_PIECES);

	// Count row lookup for an append: row read happens in ST_IDLE via cnt_rd_q path.
	logic app_q;
	logic [CW-1:0] app_cell_q;
	logic [PW-1:0] app_piece_q;
	logic [63:0] app_mask_q;
	assign app_cnt = cnt_rd_q[app_piece_q*NW +: NW];

	logic cnt_we;
	logic [NUM_PIECES*NW-1:0] cnt_new;
	assign cnt_we = app_q && app_cnt < NW'(MAX_PLACEMENTS);

	always_comb begin
		cnt_new = cnt_rd_q;
		cnt_new[app_piece_q*NW +: NW] = app_cnt + NW'(1);
	end

	always_comb begin
		cnt_cur = cnt_rd_q[p_q[PW-1:0]*NW +: NW];
	end

	// A backtrack step fetches the count row of the cell it returns to.
	logic [CW-1:0] rd_cell;
	always_comb begin
		rd_cell = cell_q[CW-1:0];
		if (s_fire) rd_cell = in_cell[CW-1:0];
		else if (state_q == ST_POP && depth_q != '0) rd_cell = stk_cell[depth_q - 1'b1];
	end

	// The row being written is forwarded to a read of the same cell in that cycle.
	always_ff @(posedge clk) begin
		if (cnt_we && rd_cell == app_cell_q) cnt_rd_q <= cnt_new;
		else cnt_rd_q <= cnt_mem[rd_cell];
		if (state_q == ST_CLR || state_q == ST_INIT)
			cnt_mem[clr_q] <= '0;
		else if (cnt_we)
			cnt_mem[app_cell_q] <= cnt_new;
	end

	logic tab_we;
	logic [$clog2(NUM_CELLS*NUM_PIECES*MAX_PLACEMENTS)-1:0] tab_wa, tab_ra;
	assign tab_we = cnt_we;
	assign tab_wa = ($bits(tab_wa))'((app_cell_q * NUM_PIECES + app_piece_q)
		* MAX_PLACEMENTS + app_cnt[KW-1:0]);
	assign tab_ra = ($bits(tab_ra))'((cell_q[CW-1:0] * NUM_PIECES + p_q[PW-1:0])
		* MAX_PLACEMENTS + k_q[KW-1:0]);
	always_ff @(posedge clk) begin
		if (tab_we) tab_mem[tab_wa] <= app_mask_q;
		tab_rd_q <= tab_mem[tab_ra];
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			app_cell_q <= in_cell[CW-1:0];
			app_piece_q <= in_piece[PW-1:0];
			app_mask_q <= in_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			clr_q <= '0;
			app_q <= 1'b0;
			out_v_q <= 1'b0;
			depth_q <= '0;
		end else begin
			app_q <= s_fire && app_ok;
			if (m_fire && state_q != ST_EMIT) out_v_q <= 1'b0;
			unique case (state_q)
				ST_INIT, ST_CLR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CW'(NUM_CELLS - 1)) begin
						clr_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_fire && op == OP_CLEAR) state_q <= ST_CLR;
					else if (s_fire && op == OP_SOLVE) begin
						cell_q <= '0;
						cov_q <= in_mask;
						used_q <= '0;
						depth_q <= '0;
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (cell_q == (CW+1)'(NUM_CELLS)) begin
						emit_q <= depth_q;
						state_q <= ST_EMIT;
					end else if (cov_q[cell_q[CW-1:0]]) cell_q <= cell_q + 1'b1;
					else begin
						p_q <= '0;
						k_q <= '0;
						state_q <= ST_CNT;
					end
				end
				ST_CNT: begin
					// Count row for cell_q is now valid in cnt_rd_q.
					if (p_q == (PW+1)'(NUM_PIECES)) state_q <= ST_POP;
					else if (used_q[p_q[PW-1:0]] || {1'b0, k_q} >= (KW+2)'(cnt_cur)) begin
						p_q <= p_q + 1'b1;
						k_q <= '0;
					end else state_q <= ST_FETCH;
				end
				ST_FETCH: state_q <= ST_TEST;
				ST_TEST: begin
					if ((tab_rd_q & cov_q) != 64'b0 || depth_q >= DW'(NUM_PIECES)) begin
						k_q <= k_q + 1'b1;
						state_q <= ST_CNT;
					end else begin
						stk_mask[depth_q] <= tab_rd_q;
						stk_cov[depth_q] <= cov_q;
						stk_p[depth_q] <= p_q[PW-1:0];
						stk_k[depth_q] <= k_q;
						stk_cell[depth_q] <= cell_q[CW-1:0];
						stk_used[depth_q] <= used_q;
						cov_q <= cov_q | tab_rd_q;
						used_q[p_q[PW-1:0]] <= 1'b1;
						depth_q <= depth_q + 1'b1;
						cell_q <= cell_q + 1'b1;
						state_q <= ST_SKIP;
					end
				end
				ST_POP: begin
					if (depth_q == '0) begin
						out_v_q <= 1'b1;
						out_found_q <= 1'b0;
						out_pv_q <= 1'b0;
						out_piece_q <= '0;
						out_mask_q <= '0;
						out_last_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						cov_q <= stk_cov[depth_q - 1'b1];
						used_q <= stk_used[depth_q - 1'b1];
						cell_q <= {1'b0, stk_cell[depth_q - 1'b1]};
						p_q <= {1'b0, stk_p[depth_q - 1'b1]};
						k_q <= stk_k[depth_q - 1'b1] + 1'b1;
						depth_q <= depth_q - 1'b1;
						state_q <= ST_CNT;
					end
				end
				ST_EMIT: begin
					if (!out_v_q || m_fire) begin
						out_v_q <= 1'b1;
						out_found_q <= 1'b1;
						if (emit_q == '0) begin
							out_pv_q <= 1'b0;
							out_piece_q <= '0;
							out_mask_q <= '0;
							out_last_q <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							out_pv_q <= 1'b1;
							out_piece_q <= 4'(stk_p[emit_q - 1'b1]);
							out_mask_q <= stk_mask[emit_q - 1'b1];
							out_last_q <= (emit_q == DW'(1));
							emit_q <= emit_q - 1'b1;
							if (emit_q == DW'(1)) state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |-> state_q == ST_IDLE) else $error("input taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(NUM_PIECES)) else $error("stack overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("output changed");
endmodule
`default_nettype wire
